[rtl/mec_pkg.sv]
// Shared types and constants of the Mandelbrot escape counter: microcode word
// layout, the control program ROM, register indexes and Q4.28 saturation.
// No dependencies.
`default_nettype none

package mec_pkg;

    localparam int STEP_W = 4;

    // Register indexes of the configuration port
    typedef enum logic [2:0] {
        CFG_REAL_ORIGIN = 3'd0,
        CFG_IMAG_ORIGIN = 3'd1,
        CFG_REAL_STEP   = 3'd2,
        CFG_IMAG_STEP   = 3'd3,
        CFG_ITER_LIMIT  = 3'd4
    } t_cfg_index;

    // Operand pair fed to the shared multiplier
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_COL,
        MUL_ROW,
        MUL_RR,
        MUL_II,
        MUL_RI
    } t_mul_sel;

    // Datapath operation of one step
    typedef enum logic [2:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_LOAD_CR,
        OP_LOAD_CI,
        OP_SAVE_SQ,
        OP_ESC_DIFF,
        OP_UPDATE,
        OP_EMIT
    } t_op;

    // Jump condition of one step
    typedef enum logic [2:0] {
        JC_NEVER,
        JC_ALWAYS,
        JC_IN_VALID,
        JC_LIMIT,
        JC_ESCAPE,
        JC_OUT_FREE
    } t_jcond;

    typedef struct packed {
        t_op               op;
        t_mul_sel          mul;
        t_jcond            cond;
        logic              hold;    // stay on this step while the condition is false
        logic [STEP_W-1:0] target;
    } t_ctrl;

    typedef struct packed {
        logic in_valid;
        logic limit_hit;
        logic escape;
        logic out_free;
    } t_status;

    localparam logic [STEP_W-1:0] STEP_IDLE  = 4'd0;
    localparam logic [STEP_W-1:0] STEP_COL   = 4'd1;
    localparam logic [STEP_W-1:0] STEP_ROW   = 4'd2;
    localparam logic [STEP_W-1:0] STEP_START = 4'd3;
    localparam logic [STEP_W-1:0] STEP_LOOP  = 4'd4;
    localparam logic [STEP_W-1:0] STEP_SQ    = 4'd5;
    localparam logic [STEP_W-1:0] STEP_ESC   = 4'd6;
    localparam logic [STEP_W-1:0] STEP_UPD   = 4'd7;
    localparam logic [STEP_W-1:0] STEP_EMIT  = 4'd8;

    localparam logic signed [44:0] Q_MAX_W = 45'sd2147483647;
    localparam logic signed [44:0] Q_MIN_W = -45'sd2147483648;

    // Control program: one word per step
    function automatic t_ctrl mec_rom(input logic [STEP_W-1:0] step);
        t_ctrl w;
        case (step)
            STEP_IDLE:  w = '{op: OP_CAPTURE, mul: MUL_NONE, cond: JC_IN_VALID,
                              hold: 1'b1, target: STEP_COL};
            STEP_COL:   w = '{op: OP_NONE, mul: MUL_COL, cond: JC_NEVER,
                              hold: 1'b0, target: STEP_IDLE};
            STEP_ROW:   w = '{op: OP_LOAD_CR, mul: MUL_ROW, cond: JC_NEVER,
                              hold: 1'b0, target: STEP_IDLE};
            STEP_START: w = '{op: OP_LOAD_CI, mul: MUL_NONE, cond: JC_NEVER,
                              hold: 1'b0, target: STEP_IDLE};
            STEP_LOOP:  w = '{op: OP_NONE, mul: MUL_RR, cond: JC_LIMIT,
                              hold: 1'b0, target: STEP_EMIT};
            STEP_SQ:    w = '{op: OP_SAVE_SQ, mul: MUL_II, cond: JC_NEVER,
                              hold: 1'b0, target: STEP_IDLE};
            STEP_ESC:   w = '{op: OP_ESC_DIFF, mul: MUL_RI, cond: JC_ESCAPE,
                              hold: 1'b0, target: STEP_EMIT};
            STEP_UPD:   w = '{op: OP_UPDATE, mul: MUL_NONE, cond: JC_ALWAYS,
                              hold: 1'b0, target: STEP_LOOP};
            STEP_EMIT:  w = '{op: OP_EMIT, mul: MUL_NONE, cond: JC_OUT_FREE,
                              hold: 1'b1, target: STEP_IDLE};
            default:    w = '{op: OP_NONE, mul: MUL_NONE, cond: JC_ALWAYS,
                              hold: 1'b0, target: STEP_IDLE};
        endcase
        return w;
    endfunction

    // Clip a wide signed value to the Q4.28 range
    function automatic logic signed [31:0] sat_q(input logic signed [44:0] v);
        logic signed [31:0] r;
        if (v > Q_MAX_W) begin
            r = 32'sh7FFFFFFF;
        end else if (v < Q_MIN_W) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/mec_sequencer.sv]
// Microcode sequencer of the Mandelbrot escape counter: step counter, program
// ROM read and conditional jumps. Depends on mec_pkg.
`default_nettype none

module mec_sequencer
    import mec_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire t_status i_status,
    output t_ctrl        o_ctrl
);

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_ctrl             w_word;
    logic              w_take;

    assign w_word = mec_rom(r_step);
    assign o_ctrl = w_word;

    always_comb begin
        case (w_word.cond)
            JC_NEVER:    w_take = 1'b0;
            JC_ALWAYS:   w_take = 1'b1;
            JC_IN_VALID: w_take = i_status.in_valid;
            JC_LIMIT:    w_take = i_status.limit_hit;
            JC_ESCAPE:   w_take = i_status.escape;
            JC_OUT_FREE: w_take = i_status.out_free;
            default:     w_take = 1'b1;
        endcase
    end

    always_comb begin
        if (w_take) begin
            n_step = w_word.target;
        end else if (w_word.hold) begin
            n_step = r_step;
        end else begin
            n_step = r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

`default_nettype wire

[rtl/mandelbrot_escape_count_unit.sv]
// Top level of the Mandelbrot escape counter: configuration registers, the
// Q4.28 datapath with one shared multiplier, and the output register.
// Depends on mec_pkg and mec_sequencer.
`default_nettype none

// Counts Mandelbrot iterations for one pixel per input beat. The point
// c = (real_origin + column*real_step, imag_origin + row*imag_step) is formed
// in signed Q4.28 with saturation, z starts at c, and z = z^2 + c repeats while
// |z|^2 <= 4 and fewer than iteration_limit updates have run; the result beat
// carries the number of updates. A microcoded sequencer drives one 32x32
// multiplier three times per iteration. The output register lets a new
// pixel be taken while the previous count still waits downstream. The user
// must write configuration only while the block is idle; the block itself
// does not enforce this.

module mandelbrot_escape_count_unit
    import mec_pkg::*;
#(
    parameter int MAX_DIM = 4096
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // configuration write channel
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [31:0] i_cfg_data,
    // pixel input
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [23:0] s_axis_tdata,   // [11:0] column, [23:12] row
    // count output
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata    // [15:0] iteration_count
);

    localparam logic [16:0]        DIM_W       = 17'(MAX_DIM);
    localparam logic [11:0]        IDX_TOP     = 12'(MAX_DIM - 1);
    localparam logic [64:0]        ESC_BOUND   = 65'd1 << 58;
    localparam logic signed [63:0] DIFF_BOUND  = 64'sd288230376151711744;

    // configuration
    logic signed [31:0] r_real_origin;
    logic signed [31:0] r_imag_origin;
    logic [30:0]        r_real_step;
    logic [30:0]        r_imag_step;
    logic [15:0]        r_iter_limit;

    // datapath
    logic [11:0]        r_col;
    logic [11:0]        r_row;
    logic signed [63:0] r_prod;
    logic signed [63:0] r_acc;
    logic signed [31:0] r_cr;
    logic signed [31:0] r_ci;
    logic signed [31:0] r_zr;
    logic signed [31:0] r_zi;
    logic [15:0]        r_count;
    logic               r_out_valid;
    logic [15:0]        r_out_data;

    t_ctrl              w_ctrl;
    t_status            w_status;
    logic signed [31:0] w_mul_a;
    logic signed [31:0] w_mul_b;
    logic signed [63:0] w_prod;
    logic [11:0]        w_col_c;
    logic [11:0]        w_row_c;
    logic signed [44:0] w_cr_sum;
    logic signed [44:0] w_ci_sum;
    logic signed [44:0] w_zr_sum;
    logic signed [44:0] w_zi_sum;
    logic [64:0]        w_sq_sum;
    logic               w_out_free;

    mec_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_ctrl   (w_ctrl)
    );

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (w_ctrl.op == OP_CAPTURE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_sq_sum   = {1'b0, r_acc} + {1'b0, r_prod};

    assign w_status.in_valid  = s_axis_tvalid;
    assign w_status.limit_hit = (r_count >= r_iter_limit);
    assign w_status.escape    = (w_sq_sum > ESC_BOUND);
    assign w_status.out_free  = w_out_free;

    assign w_col_c = ({5'b0, s_axis_tdata[11:0]} >= DIM_W) ? IDX_TOP : s_axis_tdata[11:0];
    assign w_row_c = ({5'b0, s_axis_tdata[23:12]} >= DIM_W) ? IDX_TOP : s_axis_tdata[23:12];

    always_comb begin
        case (w_ctrl.mul)
            MUL_COL: begin
                w_mul_a = $signed({20'b0, r_col});
                w_mul_b = $signed({1'b0, r_real_step});
            end
            MUL_ROW: begin
                w_mul_a = $signed({20'b0, r_row});
                w_mul_b = $signed({1'b0, r_imag_step});
            end
            MUL_II: begin
                w_mul_a = r_zi;
                w_mul_b = r_zi;
            end
            MUL_RI: begin
                w_mul_a = r_zr;
                w_mul_b = r_zi;
            end
            default: begin
                w_mul_a = r_zr;
                w_mul_b = r_zr;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // point setup: product is a nonnegative index times step below 2^43
    assign w_cr_sum = $signed({1'b0, r_prod[43:0]}) + 45'(r_real_origin);
    assign w_ci_sum = $signed({1'b0, r_prod[43:0]}) + 45'(r_imag_origin);

    // round Q8.56 to Q4.28 (half up) and add c in one adder; r_prod doubled for 2*zr*zi
    assign w_zr_sum = 45'($signed(r_acc[63:28])) + 45'(r_cr) + {44'b0, r_acc[27]};
    assign w_zi_sum = 45'($signed(r_prod[63:27])) + 45'(r_ci) + {44'b0, r_prod[26]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_real_origin <= -32'sd536870912;
            r_imag_origin <= -32'sd402653184;
            r_real_step   <= 31'd196608;
            r_imag_step   <= 31'd196608;
            r_iter_limit  <= 16'd100;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_REAL_ORIGIN: r_real_origin <= i_cfg_data;
                CFG_IMAG_ORIGIN: r_imag_origin <= i_cfg_data;
                CFG_REAL_STEP:   r_real_step   <= i_cfg_data[30:0];
                CFG_IMAG_STEP:   r_imag_step   <= i_cfg_data[30:0];
                CFG_ITER_LIMIT:  r_iter_limit  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.mul != MUL_NONE) begin
            r_prod <= w_prod;
        end
        case (w_ctrl.op)
            OP_CAPTURE: begin
                if (s_axis_tvalid) begin
                    r_col <= w_col_c;
                    r_row <= w_row_c;
                end
            end
            OP_LOAD_CR: begin
                r_cr <= sat_q(w_cr_sum);
                r_zr <= sat_q(w_cr_sum);
            end
            OP_LOAD_CI: begin
                r_ci    <= sat_q(w_ci_sum);
                r_zi    <= sat_q(w_ci_sum);
                r_count <= '0;
            end
            OP_SAVE_SQ: r_acc <= r_prod;
            OP_ESC_DIFF: r_acc <= r_acc - r_prod;
            OP_UPDATE: begin
                r_zr    <= sat_q(w_zr_sum);
                r_zi    <= sat_q(w_zi_sum);
                r_count <= r_count + 1'b1;
            end
            OP_EMIT: begin
                if (w_out_free) begin
                    r_out_data <= r_count;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.op == OP_EMIT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // an update only happens below the limit
    a_count_below_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.op == OP_UPDATE) |-> (r_count < r_iter_limit))
        else $error("update past iteration limit");

    // a non-escaped point keeps zr^2 - zi^2 within +-4.0
    a_diff_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.op == OP_UPDATE) |-> (r_acc <= DIFF_BOUND && r_acc >= -DIFF_BOUND))
        else $error("square difference out of range at update");

    // an accepted pixel starts the column multiply next
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (w_ctrl.mul == MUL_COL))
        else $error("accepted pixel did not start setup");

    // emitting into a free output register raises valid and returns to idle
    a_emit_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.op == OP_EMIT && w_out_free) |=> (r_out_valid && w_ctrl.op == OP_CAPTURE))
        else $error("emitted count lost");

endmodule

`default_nettype wire

[tb/tb_mandelbrot_escape_count_unit.sv]
// Self-checking testbench for mandelbrot_escape_count_unit: pixel beats in,
// escape counts out, checked against an in-bench fixed-point escape-time model.
// Depends on mec_pkg and the RTL of the unit.
`timescale 1ns / 1ps

module tb_mandelbrot_escape_count_unit;
    import mec_pkg::*;

    localparam int          MAX_DIM       = 4096;
    localparam logic [63:0] ESCAPE_Q56    = 64'd1 << 58;
    localparam longint      Q28_MAX       = 64'sd2147483647;
    localparam longint      Q28_MIN       = -64'sd2147483648;
    localparam int          REG_SPARE_LO  = int'(CFG_ITER_LIMIT) + 1;
    localparam int          REG_INDEX_TOP = 7;
    localparam int          LONG_HOLD     = 1500;
    localparam int          HOLD_AT_COUNT = 120;

    typedef struct packed {
        logic [11:0] row;
        logic [11:0] col;
    } t_pixel;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;     // [11:0] column, [23:12] row
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // [15:0] iteration_count

    // view registers as the block should hold them
    logic signed [31:0] re_origin = -32'sd536870912;
    logic signed [31:0] im_origin = -32'sd402653184;
    logic [30:0]        re_step   = 31'd196608;
    logic [30:0]        im_step   = 31'd196608;
    logic [15:0]        iter_cap  = 16'd100;

    t_pixel      pixel_q[$];
    logic [15:0] count_q[$];

    int     fail_cnt = 0;
    int     results_seen = 0;
    longint cycle_cnt = 0;
    longint cycle_budget = 20000 + LONG_HOLD;
    bit     quiet_tail = 1'b0;

    int src_gap = 0;
    bit src_calm = 1'b0;
    int hold_left = 0;
    bit snk_calm = 1'b0;

    mandelbrot_escape_count_unit #(.MAX_DIM(MAX_DIM)) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint q_clip(input longint v);
        if (v > Q28_MAX) begin
            return Q28_MAX;
        end else if (v < Q28_MIN) begin
            return Q28_MIN;
        end
        return v;
    endfunction

    // Q8.56 to Q4.28, ties toward plus infinity
    function automatic longint round_q28(input longint v);
        return (v + (longint'(1) <<< 27)) >>> 28;
    endfunction

    function automatic logic [15:0] escape_count(input logic [11:0] col_in,
                                                 input logic [11:0] row_in);
        int unsigned col;
        int unsigned row;
        longint      cr, ci, zr, zi, r2, i2, ri;
        logic [63:0] mag;
        int unsigned n;
        bit          escaped;
        col = (col_in >= MAX_DIM) ? MAX_DIM - 1 : col_in;
        row = (row_in >= MAX_DIM) ? MAX_DIM - 1 : row_in;
        cr = q_clip(longint'(re_origin) + longint'(col) * longint'(re_step));
        ci = q_clip(longint'(im_origin) + longint'(row) * longint'(im_step));
        zr = cr;
        zi = ci;
        n = 0;
        escaped = 1'b0;
        while (n < iter_cap && !escaped) begin
            r2 = zr * zr;
            i2 = zi * zi;
            mag = r2 + i2;
            if (mag > ESCAPE_Q56) begin
                escaped = 1'b1;
            end else begin
                ri = 2 * zr * zi;
                zr = q_clip(round_q28(r2 - i2) + cr);
                zi = q_clip(round_q28(ri) + ci);
                n++;
            end
        end
        return n[15:0];
    endfunction

    // ---------------- pixel driver ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                count_q.push_back(escape_count(s_axis_tdata[11:0], s_axis_tdata[23:12]));
                if ($urandom_range(0, 49) == 0) src_calm = !src_calm;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap == 0 && !src_calm && !quiet_tail && $urandom_range(0, 7) == 0)
                    src_gap = $urandom_range(1, 13);
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pixel_q.size() > 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pixel_q.pop_front();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------- count monitor ----------------
    always @(posedge i_clk) begin
        logic [15:0] want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (count_q.size() == 0) begin
                    $error("iteration_count: expected none, actual %0d", m_axis_tdata);
                    fail_cnt++;
                end else begin
                    want = count_q.pop_front();
                    if (m_axis_tdata !== want) begin
                        $error("iteration_count: expected %0d, actual %0d",
                               want, m_axis_tdata);
                        fail_cnt++;
                    end
                end
                results_seen++;
                // hold off long enough for the unit to back up into its input
                if (results_seen == HOLD_AT_COUNT) hold_left = LONG_HOLD;
                if ($urandom_range(0, 49) == 0) snk_calm = !snk_calm;
            end
            if (hold_left == 0 && !snk_calm && !quiet_tail && $urandom_range(0, 7) == 0)
                hold_left = $urandom_range(1, 13);
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 3 * cycle_budget + 20000) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_REAL_ORIGIN: re_origin = val;
            CFG_IMAG_ORIGIN: im_origin = val;
            CFG_REAL_STEP:   re_step   = val[30:0];
            CFG_IMAG_STEP:   im_step   = val[30:0];
            CFG_ITER_LIMIT:  iter_cap  = val[15:0];
            default: ;
        endcase
        cycle_budget += 16;
    endtask

    task automatic set_view(input logic [31:0] ro, input logic [31:0] io,
                            input logic [31:0] rs, input logic [31:0] is_,
                            input logic [31:0] lim);
        write_reg(CFG_REAL_ORIGIN, ro);
        write_reg(CFG_IMAG_ORIGIN, io);
        write_reg(CFG_REAL_STEP, rs);
        write_reg(CFG_IMAG_STEP, is_);
        write_reg(CFG_ITER_LIMIT, lim);
    endtask

    task automatic queue_pixel(input int col, input int row);
        t_pixel p;
        p.col = col[11:0];
        p.row = row[11:0];
        pixel_q.push_back(p);
        cycle_budget += 4 * longint'(iter_cap) + 48;
    endtask

    task automatic queue_random(input int n, input int col_lo);
        repeat (n) queue_pixel($urandom_range(col_lo, MAX_DIM - 1),
                               $urandom_range(0, MAX_DIM - 1));
    endtask

    // wait until every count is back and the unit has gone idle
    task automatic settle();
        while (pixel_q.size() > 0 || s_axis_tvalid || count_q.size() > 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic random_view();
        logic [31:0] ro, io, rs, is_, lim;
        ro  = $urandom_range(0, 1342177280) - 805306368;
        io  = $urandom_range(0, 1073741824) - 536870912;
        rs  = ($urandom & 32'h8000_0000) | $urandom_range(0, 1 << 18);
        is_ = ($urandom & 32'h8000_0000) | $urandom_range(0, 1 << 18);
        lim = ($urandom & 32'hFFFF_0000) | $urandom_range(1, 40);
        set_view(ro, io, rs, is_, lim);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corners, the set interior and a walking bit on both indexes
        queue_pixel(0, 0);
        queue_pixel(MAX_DIM - 1, MAX_DIM - 1);
        queue_pixel(0, MAX_DIM - 1);
        queue_pixel(MAX_DIM - 1, 0);
        queue_pixel(2048, 2048);
        queue_pixel(2730, 2048);
        queue_pixel(MAX_DIM - 1, 2048);
        for (int k = 0; k < 12; k++) queue_pixel(1 << k, (MAX_DIM - 1) ^ (1 << k));
        settle();

        // default view, with a long output stall early on
        queue_random(300, 0);
        settle();

        // zero limit, most positive / most negative origins, widest steps
        set_view(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0);
        for (int k = REG_SPARE_LO; k <= REG_INDEX_TOP; k++) write_reg(k[2:0], $urandom);
        queue_random(200, 0);
        settle();

        // point clipped at both ends of the range
        set_view(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd7);
        queue_pixel(0, 0);
        queue_pixel(1, 1);
        queue_random(200, 0);
        settle();

        // zoom on the boundary, flat in the imaginary direction
        set_view(-32'sd201326592, 32'sd26843546, $urandom_range(1, 8192), 32'h0,
                 32'd200);
        for (int k = REG_SPARE_LO; k <= REG_INDEX_TOP; k++) write_reg(k[2:0], '1);
        queue_random(120, 0);
        settle();

        // full limit: the origin never escapes, everything else escapes fast
        set_view(32'h0, 32'h0, 32'h1000_0000, 32'h1000_0000, 32'hFFFF_FFFF);
        queue_pixel(0, 0);
        queue_random(40, 1);
        settle();

        random_view();
        queue_random(200, 0);
        settle();

        // tail without idling on either side
        quiet_tail = 1'b1;
        random_view();
        queue_random(150, 0);
        settle();

        if (fail_cnt == 0 && count_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
